FILE: rtl/msp_pkg.sv
// Shared types, codes and the CRC-8 (0xD5) byte update for the MSP frame parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package msp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned TdataW = 64;

  localparam logic [WordW-1:0] MaxPayloadReset = 16'd1024;

  localparam logic [ByteW-1:0] ChSync    = 8'h24; // '$'
  localparam logic [ByteW-1:0] ChV1      = 8'h4D; // 'M'
  localparam logic [ByteW-1:0] ChV2      = 8'h58; // 'X'
  localparam logic [ByteW-1:0] ChFromFc  = 8'h3E; // '>'
  localparam logic [ByteW-1:0] ChToFc    = 8'h3C; // '<'
  localparam logic [ByteW-1:0] ChUnsup   = 8'h21; // '!'
  localparam logic [ByteW-1:0] JumboMark = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly   = 8'hD5;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD      = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_t;

  typedef enum logic [16:0] {
    ST_IDLE       = 17'b00000000000000001,
    ST_PROTO      = 17'b00000000000000010,
    ST_DIR_V1     = 17'b00000000000000100,
    ST_DIR_V2     = 17'b00000000000001000,
    ST_FLAG_V2    = 17'b00000000000010000,
    ST_LEN_V1     = 17'b00000000000100000,
    ST_CODE_V1    = 17'b00000000001000000,
    ST_CODE_JUMBO = 17'b00000000010000000,
    ST_JLEN_LO    = 17'b00000000100000000,
    ST_JLEN_HI    = 17'b00000001000000000,
    ST_CODE_V2_LO = 17'b00000010000000000,
    ST_CODE_V2_HI = 17'b00000100000000000,
    ST_LEN_V2_LO  = 17'b00001000000000000,
    ST_LEN_V2_HI  = 17'b00010000000000000,
    ST_PAYLOAD    = 17'b00100000000000000,
    ST_CHECK_V1   = 17'b01000000000000000,
    ST_CHECK_V2   = 17'b10000000000000000
  } parse_state_t;

  // One result item as produced by the parse core.
  typedef struct packed {
    kind_t            kind;
    logic             version;
    logic             direction;
    logic             unsupported;
    logic [WordW-1:0] command;
    logic [WordW-1:0] payload_length;
    logic [ByteW-1:0] data_byte;
    logic [WordW-1:0] byte_index;
  } result_t;

  // Status of the parse core seen by the top level.
  typedef struct packed {
    parse_state_t state;
    logic         in_frame;
  } core_status_t;

  // CRC-8 with polynomial 0xD5, one byte, MSB first.
  function automatic logic [ByteW-1:0] crc_d5(input logic [ByteW-1:0] crc,
                                              input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msp_in_reg.sv
// Input register stage of the MSP frame parser: holds one received byte.
// Depends on msp_pkg for widths.
`default_nettype none

module msp_in_reg
  import msp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,
  input  wire logic             advance,
  output logic                  byte_valid,
  output logic      [ByteW-1:0] rx_byte
);

  // The stage may refill in the same cycle that its byte moves on.
  assign s_axis_tready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rx_byte <= s_axis_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msp_parse_core.sv
// Frame state machine, check sums and length limit of the MSP frame parser.
// Depends on msp_pkg for the state codes, result type and CRC function.
`default_nettype none

module msp_parse_core
  import msp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [WordW-1:0] cfg_wr_data,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  output logic                  res_valid,
  output result_t               res,
  output core_status_t          status
);

  parse_state_t     parse_state, parse_state_next;
  logic             is_v2, is_v2_next;
  logic             is_jumbo, is_jumbo_next;
  logic             dir_bit, dir_bit_next;
  logic             unsup_bit, unsup_bit_next;
  logic [WordW-1:0] cmd_code, cmd_code_next;
  logic [WordW-1:0] expected_len, expected_len_next;
  logic [WordW-1:0] received_count, received_count_next;
  logic [ByteW-1:0] xor_sum, xor_sum_next;
  logic [ByteW-1:0] running_crc, running_crc_next;
  logic [WordW-1:0] max_payload;

  kind_t            kind;
  logic [ByteW-1:0] data_out;
  logic [WordW-1:0] index_out;
  logic [WordW-1:0] count_inc;
  logic [ByteW-1:0] crc_upd;
  logic             len_done;
  parse_state_t     check_state;

  assign crc_upd     = crc_d5(running_crc, rx_byte);
  assign count_inc   = received_count + 16'd1;
  assign check_state = is_v2 ? ST_CHECK_V2 : ST_CHECK_V1;

  always_comb begin
    parse_state_next    = parse_state;
    is_v2_next          = is_v2;
    is_jumbo_next       = is_jumbo;
    dir_bit_next        = dir_bit;
    unsup_bit_next      = unsup_bit;
    cmd_code_next       = cmd_code;
    expected_len_next   = expected_len;
    received_count_next = received_count;
    xor_sum_next        = xor_sum;
    running_crc_next    = running_crc;
    res_valid           = 1'b0;
    kind                = KIND_PAYLOAD;
    data_out            = '0;
    index_out           = '0;
    len_done            = 1'b0;

    case (parse_state)
      ST_IDLE: begin
        if (rx_byte == ChSync) begin
          parse_state_next = ST_PROTO;
        end
      end
      ST_PROTO: begin
        is_jumbo_next       = 1'b0;
        cmd_code_next       = '0;
        expected_len_next   = '0;
        received_count_next = '0;
        xor_sum_next        = '0;
        running_crc_next    = '0;
        if (rx_byte == ChV1) begin
          is_v2_next       = 1'b0;
          parse_state_next = ST_DIR_V1;
        end else if (rx_byte == ChV2) begin
          is_v2_next       = 1'b1;
          parse_state_next = ST_DIR_V2;
        end else begin
          parse_state_next = ST_IDLE;
        end
      end
      ST_DIR_V1, ST_DIR_V2: begin
        unsup_bit_next = 1'b0;
        if (rx_byte == ChFromFc) begin
          dir_bit_next = 1'b1;
        end else if (rx_byte == ChToFc) begin
          dir_bit_next = 1'b0;
        end else if (rx_byte == ChUnsup) begin
          unsup_bit_next = 1'b1;
        end
        parse_state_next = (parse_state == ST_DIR_V1) ? ST_LEN_V1 : ST_FLAG_V2;
      end
      ST_FLAG_V2: begin
        running_crc_next = crc_d5('0, rx_byte);
        parse_state_next = ST_CODE_V2_LO;
      end
      ST_CODE_V2_LO: begin
        cmd_code_next    = {8'd0, rx_byte};
        running_crc_next = crc_upd;
        parse_state_next = ST_CODE_V2_HI;
      end
      ST_CODE_V2_HI: begin
        cmd_code_next    = {rx_byte, cmd_code[ByteW-1:0]};
        running_crc_next = crc_upd;
        parse_state_next = ST_LEN_V2_LO;
      end
      ST_LEN_V2_LO: begin
        expected_len_next = {8'd0, rx_byte};
        running_crc_next  = crc_upd;
        parse_state_next  = ST_LEN_V2_HI;
      end
      ST_LEN_V2_HI: begin
        expected_len_next = {rx_byte, expected_len[ByteW-1:0]};
        running_crc_next  = crc_upd;
        len_done          = 1'b1;
      end
      ST_LEN_V1: begin
        xor_sum_next = rx_byte;
        if (rx_byte == JumboMark) begin
          is_jumbo_next     = 1'b1;
          expected_len_next = '0;
          parse_state_next  = ST_CODE_JUMBO;
        end else begin
          expected_len_next = {8'd0, rx_byte};
          parse_state_next  = ST_CODE_V1;
        end
      end
      ST_CODE_V1: begin
        cmd_code_next = {8'd0, rx_byte};
        xor_sum_next  = xor_sum ^ rx_byte;
        len_done      = 1'b1;
      end
      ST_CODE_JUMBO: begin
        cmd_code_next    = {8'd0, rx_byte};
        xor_sum_next     = xor_sum ^ rx_byte;
        parse_state_next = ST_JLEN_LO;
      end
      ST_JLEN_LO: begin
        expected_len_next = {8'd0, rx_byte};
        xor_sum_next      = xor_sum ^ rx_byte;
        parse_state_next  = ST_JLEN_HI;
      end
      ST_JLEN_HI: begin
        expected_len_next = {rx_byte, expected_len[ByteW-1:0]};
        xor_sum_next      = xor_sum ^ rx_byte;
        len_done          = 1'b1;
      end
      ST_PAYLOAD: begin
        xor_sum_next        = xor_sum ^ rx_byte;
        running_crc_next    = crc_upd;
        received_count_next = count_inc;
        if (count_inc >= expected_len) begin
          parse_state_next = check_state;
        end
        res_valid = 1'b1;
        kind      = KIND_PAYLOAD;
        data_out  = rx_byte;
        index_out = received_count;
      end
      ST_CHECK_V1: begin
        parse_state_next = ST_IDLE;
        res_valid        = 1'b1;
        kind             = (xor_sum == rx_byte) ? KIND_GOOD : KIND_BAD;
      end
      ST_CHECK_V2: begin
        parse_state_next = ST_IDLE;
        res_valid        = 1'b1;
        kind             = (running_crc == rx_byte) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        parse_state_next = ST_IDLE;
      end
    endcase

    // Once the command and length are known, enforce the limit and pick the
    // next phase; a zero length skips straight to the check byte.
    if (len_done) begin
      if (expected_len_next > max_payload) begin
        parse_state_next = ST_IDLE;
        res_valid        = 1'b1;
        kind             = KIND_OVERSIZE;
      end else begin
        received_count_next = '0;
        parse_state_next    = (expected_len_next == '0) ? check_state : ST_PAYLOAD;
      end
    end
  end

  // Result fields carry the frame header as it stands after this byte.
  always_comb begin
    res.kind           = kind;
    res.version        = is_v2_next;
    res.direction      = dir_bit_next;
    res.unsupported    = unsup_bit_next;
    res.command        = cmd_code_next;
    res.payload_length = expected_len_next;
    res.data_byte      = data_out;
    res.byte_index     = index_out;
  end

  assign status.state    = parse_state;
  assign status.in_frame = (parse_state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ST_IDLE;
      is_v2          <= 1'b0;
      is_jumbo       <= 1'b0;
      dir_bit        <= 1'b0;
      unsup_bit      <= 1'b0;
      cmd_code       <= '0;
      expected_len   <= '0;
      received_count <= '0;
      xor_sum        <= '0;
      running_crc    <= '0;
    end else if (step) begin
      parse_state    <= parse_state_next;
      is_v2          <= is_v2_next;
      is_jumbo       <= is_jumbo_next;
      dir_bit        <= dir_bit_next;
      unsup_bit      <= unsup_bit_next;
      cmd_code       <= cmd_code_next;
      expected_len   <= expected_len_next;
      received_count <= received_count_next;
      xor_sum        <= xor_sum_next;
      running_crc    <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadReset;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msp_out_reg.sv
// Result register of the MSP frame parser: holds one result item for the sink.
// Depends on msp_pkg for the result type and bus widths.
`default_nettype none

module msp_out_reg
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire result_t           res,
  output logic                   space,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [TdataW-1:0] m_axis_tdata,
  output logic      [KindW-1:0]  m_axis_tuser
);

  // Room for a new item when empty or when the held item leaves this cycle.
  assign space = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tuser <= res.kind;
      m_axis_tdata <= {5'd0, res.byte_index, res.data_byte, res.payload_length,
                       res.command, res.unsupported, res.direction, res.version};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msp_frame_parser_unit.sv
// Top level of the MSP v1/v2 frame parser: input register, parse core and
// result register. Depends on msp_pkg, msp_in_reg, msp_parse_core, msp_out_reg.
// Each accepted byte waits in the input register and steps the parse core; any
// result item then goes to the result register. Throughput: one byte per cycle;
// a held result item whose sink is not ready stalls byte input until it leaves.
// Reset (rst, synchronous, active high) empties both registers, returns the
// parser to idle and sets max_payload to 1024.
`default_nettype none

module msp_frame_parser_unit
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration: max_payload.
  input  wire logic              cfg_wr_en,
  input  wire logic [WordW-1:0]  cfg_wr_data,
  // Received bytes.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [ByteW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result items.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] version, [1] direction, [2] unsupported, [18:3] command,
  // [34:19] payload_length, [42:35] data_byte, [58:43] byte_index, rest zero
  output logic      [TdataW-1:0] m_axis_tdata,
  output logic      [KindW-1:0]  m_axis_tuser    // [1:0] kind
);

  logic             byte_valid;
  logic [ByteW-1:0] rx_byte;
  logic             out_space;
  logic             step;
  logic             res_valid;
  result_t          res;
  core_status_t     core_status;

  // The held byte steps the parser whenever the result register has room, so
  // every byte, with or without a result, waits for that room.
  assign step = byte_valid && out_space;

  msp_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (step),
    .byte_valid    (byte_valid),
    .rx_byte       (rx_byte)
  );

  msp_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res         (res),
    .status      (core_status)
  );

  msp_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .space         (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The parser state register is one-hot at all times.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(core_status.state))
    else $error("parse state is not one-hot");

  // A result is never produced while the parser sits idle on the prior byte.
  a_no_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    (step && !core_status.in_frame) |-> !res_valid)
    else $error("result produced from idle state");

  // Verdict and drop items carry zero data byte and index.
  a_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |->
      (m_axis_tdata[58:35] == 24'd0))
    else $error("verdict item with nonzero data fields");

  // A payload byte index always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |->
      (m_axis_tdata[58:43] < m_axis_tdata[34:19]))
    else $error("payload byte index beyond declared length");

endmodule

`default_nettype wire
